// ===== sv/apq_pkg.sv =====
// Shared types and constants for the aging priority queue.
// No dependencies; used by the queue unit.
package apq_pkg;

    localparam int NUM_PROCS = 16;
    localparam int ID_W      = $clog2(NUM_PROCS);
    localparam int CNT_W     = $clog2(NUM_PROCS + 1);
    localparam int PRIO_W    = 4;
    localparam int TIMER_W   = 16;
    localparam int SUM_W     = 32;
    localparam int QCNT_W    = 16;
    localparam int CFG_W     = 16;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_INSERT  = 2'd1,
        FUNC_DEQUEUE = 2'd2,
        FUNC_NOP     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        CFG_AGING_PERIOD = 1'b0,
        CFG_MAX_PRIORITY = 1'b1
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_SHIFT,
        S_DEQ_RD,
        S_DEQ_WR,
        S_AGE_RD,
        S_AGE_CHK,
        S_AGE_DIV,
        S_AGE_WR,
        S_SORT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [TIMER_W-1:0] timer;
        logic [TIMER_W-1:0] wmin;
        logic [TIMER_W-1:0] wmax;
        logic [SUM_W-1:0]   wsum;
        logic [QCNT_W-1:0]  qcnt;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== sv/apq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module apq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/aging_priority_queue_unit.sv =====
// Aging priority queue: one result per request, registered after the last step.
// Insert: read, write, shift past higher keys. Dequeue: read, write. Failed request or
// empty tick: result at once. Tick, per entry: read, check, 16-step remainder (skipped
// for period zero), write (both skipped for a saturated timer); then 16 sort passes.
// Sequential: next request is taken the cycle after the result is registered.
// Synchronous active-low reset empties the queue and marks all per-id state zero.
// Uses apq_pkg and apq_ram.
module aging_priority_queue_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_func,
    input  logic [3:0]                   i_proc_id,
    input  logic [3:0]                   i_base_priority,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [3:0]                   o_out_id,
    output logic [15:0]                  o_out_wait,
    output logic [15:0]                  o_out_wait_min,
    output logic [15:0]                  o_out_wait_max,
    output logic [31:0]                  o_out_wait_sum,
    output logic [15:0]                  o_out_times_queued,
    output logic [4:0]                   o_occupancy,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [apq_pkg::CFG_W-1:0]    i_cfg_data
);

    apq_pkg::t_state                  r_state, n_state;
    logic [apq_pkg::ID_W-1:0]         r_id;
    logic [apq_pkg::PRIO_W-1:0]       r_prio_in;
    logic [apq_pkg::CNT_W-1:0]        r_count;
    logic [apq_pkg::ID_W-1:0]         r_order [apq_pkg::NUM_PROCS];
    logic [apq_pkg::PRIO_W-1:0]       r_key   [apq_pkg::NUM_PROCS];
    logic [apq_pkg::CNT_W-1:0]        r_idx;
    logic [apq_pkg::ID_W-1:0]         r_pass;
    logic [3:0]                       r_bit;
    logic [apq_pkg::TIMER_W-1:0]      r_rem;
    apq_pkg::t_entry                  r_entry;
    logic [apq_pkg::TIMER_W-1:0]      r_period;
    logic [apq_pkg::PRIO_W-1:0]       r_maxp;
    logic [apq_pkg::NUM_PROCS-1:0]    r_mem_valid;
    logic                             r_rd_valid;

    apq_pkg::t_status                 r_res_status;
    apq_pkg::t_entry                  r_res;
    logic [apq_pkg::ID_W-1:0]         r_res_id;
    logic [apq_pkg::TIMER_W-1:0]      r_res_wait;

    logic                             r_out_valid;
    logic [1:0]                       r_o_status;
    logic [3:0]                       r_o_id;
    logic [15:0]                      r_o_wait, r_o_min, r_o_max, r_o_qcnt;
    logic [31:0]                      r_o_sum;
    logic [4:0]                       r_o_occ;

    logic                             in_acc;
    logic                             done_go;
    logic                             mem_we;
    logic [apq_pkg::ID_W-1:0]         mem_waddr, mem_raddr;
    apq_pkg::t_entry                  mem_wdata, mem_rdata, rd;
    apq_pkg::t_entry                  ins_e, deq_e, age_e, chk_e;
    logic [apq_pkg::ID_W-1:0]         top_id;
    logic [apq_pkg::ID_W-1:0]         ip, ip1;
    logic                             shift_on;
    logic [apq_pkg::TIMER_W:0]        rem_sh;
    logic [apq_pkg::TIMER_W-1:0]      rem_nx;
    logic [apq_pkg::SUM_W:0]          sum_ext;
    logic                             last_slot;

    apq_ram #(
        .DEPTH (apq_pkg::NUM_PROCS),
        .WIDTH (apq_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd        = r_rd_valid ? mem_rdata : '0;
    assign in_acc    = i_in_valid && o_in_ready;
    assign done_go   = (r_state == apq_pkg::S_DONE) && (!r_out_valid || i_out_ready);
    assign top_id    = r_order[apq_pkg::ID_W'(r_count - 1'b1)];
    assign ip        = r_idx[apq_pkg::ID_W-1:0];
    assign ip1       = apq_pkg::ID_W'(r_idx - 1'b1);
    assign shift_on  = (r_idx != '0) && (r_key[ip1] > r_prio_in);
    assign rem_sh    = {r_rem, r_entry.timer[r_bit]};
    assign rem_nx    = (rem_sh >= {1'b0, r_period}) ? apq_pkg::TIMER_W'(rem_sh - {1'b0, r_period})
                                                    : rem_sh[apq_pkg::TIMER_W-1:0];
    assign sum_ext   = {1'b0, rd.wsum} + {{(apq_pkg::SUM_W-apq_pkg::TIMER_W+1){1'b0}}, rd.timer};
    assign last_slot = (r_idx + 1'b1) == r_count;

    always_comb begin
        ins_e       = rd;
        ins_e.prio  = r_prio_in;
        ins_e.timer = '0;
        if (rd.qcnt != '1) begin
            ins_e.qcnt = rd.qcnt + 1'b1;
        end

        deq_e = rd;
        if (rd.wmin == '0 || rd.timer < rd.wmin) begin
            deq_e.wmin = rd.timer;
        end
        if (rd.timer > rd.wmax) begin
            deq_e.wmax = rd.timer;
        end
        deq_e.wsum  = sum_ext[apq_pkg::SUM_W] ? '1 : sum_ext[apq_pkg::SUM_W-1:0];
        deq_e.timer = '0;

        chk_e       = rd;
        chk_e.timer = rd.timer + 1'b1;

        age_e = r_entry;
        if (r_period != '0 && r_rem == '0 && r_entry.prio < r_maxp) begin
            age_e.prio = r_entry.prio + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            apq_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (apq_pkg::t_func'(i_func))
                        apq_pkg::FUNC_TICK:
                            n_state = (r_count == '0) ? apq_pkg::S_DONE : apq_pkg::S_AGE_RD;
                        apq_pkg::FUNC_INSERT:
                            n_state = (r_count == apq_pkg::CNT_W'(apq_pkg::NUM_PROCS))
                                    ? apq_pkg::S_DONE : apq_pkg::S_INS_RD;
                        apq_pkg::FUNC_DEQUEUE:
                            n_state = (r_count == '0) ? apq_pkg::S_DONE : apq_pkg::S_DEQ_RD;
                        default:
                            n_state = apq_pkg::S_DONE;
                    endcase
                end
            end
            apq_pkg::S_INS_RD:    n_state = apq_pkg::S_INS_WR;
            apq_pkg::S_INS_WR:    n_state = apq_pkg::S_INS_SHIFT;
            apq_pkg::S_INS_SHIFT: n_state = shift_on ? apq_pkg::S_INS_SHIFT : apq_pkg::S_DONE;
            apq_pkg::S_DEQ_RD:    n_state = apq_pkg::S_DEQ_WR;
            apq_pkg::S_DEQ_WR:    n_state = apq_pkg::S_DONE;
            apq_pkg::S_AGE_RD:    n_state = apq_pkg::S_AGE_CHK;
            apq_pkg::S_AGE_CHK: begin
                if (rd.timer == '1) begin
                    n_state = last_slot ? apq_pkg::S_SORT : apq_pkg::S_AGE_RD;
                end else if (r_period == '0) begin
                    n_state = apq_pkg::S_AGE_WR;
                end else begin
                    n_state = apq_pkg::S_AGE_DIV;
                end
            end
            apq_pkg::S_AGE_DIV:   n_state = (r_bit == '0) ? apq_pkg::S_AGE_WR : apq_pkg::S_AGE_DIV;
            apq_pkg::S_AGE_WR:    n_state = last_slot ? apq_pkg::S_SORT : apq_pkg::S_AGE_RD;
            apq_pkg::S_SORT:      n_state = (r_pass == '1) ? apq_pkg::S_DONE : apq_pkg::S_SORT;
            apq_pkg::S_DONE:      n_state = done_go ? apq_pkg::S_IDLE : apq_pkg::S_DONE;
            default:              n_state = apq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == apq_pkg::S_IDLE);
        mem_we     = 1'b0;
        mem_waddr  = r_id;
        mem_wdata  = age_e;
        mem_raddr  = r_id;
        case (r_state)
            apq_pkg::S_AGE_RD: mem_raddr = r_order[ip];
            apq_pkg::S_INS_WR: begin
                mem_we    = 1'b1;
                mem_wdata = ins_e;
            end
            apq_pkg::S_DEQ_WR: begin
                mem_we    = 1'b1;
                mem_wdata = deq_e;
            end
            apq_pkg::S_AGE_WR: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apq_pkg::S_IDLE;
            r_count     <= '0;
            r_mem_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= apq_pkg::TIMER_W'(30);
            r_maxp      <= apq_pkg::PRIO_W'(15);
        end else begin
            r_state    <= n_state;
            r_rd_valid <= r_mem_valid[mem_raddr];
            if (mem_we) begin
                r_mem_valid[mem_waddr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (apq_pkg::t_cfg'(i_cfg_index))
                    apq_pkg::CFG_AGING_PERIOD: r_period <= i_cfg_data[apq_pkg::TIMER_W-1:0];
                    apq_pkg::CFG_MAX_PRIORITY: r_maxp   <= i_cfg_data[apq_pkg::PRIO_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == apq_pkg::S_INS_SHIFT && !shift_on) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == apq_pkg::S_DEQ_WR) begin
                r_count <= r_count - 1'b1;
            end
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id         <= (apq_pkg::t_func'(i_func) == apq_pkg::FUNC_DEQUEUE) ? top_id
                                                                                : i_proc_id;
            r_prio_in    <= i_base_priority;
            r_idx        <= '0;
            r_pass       <= '0;
            r_res        <= '0;
            r_res_id     <= '0;
            r_res_wait   <= '0;
            if (apq_pkg::t_func'(i_func) == apq_pkg::FUNC_INSERT
                    && r_count == apq_pkg::CNT_W'(apq_pkg::NUM_PROCS)) begin
                r_res_status <= apq_pkg::ST_FULL;
            end else if (apq_pkg::t_func'(i_func) == apq_pkg::FUNC_DEQUEUE
                    && r_count == '0) begin
                r_res_status <= apq_pkg::ST_EMPTY;
            end else begin
                r_res_status <= apq_pkg::ST_OK;
            end
        end
        case (r_state)
            apq_pkg::S_INS_WR: begin
                for (int k = 0; k < apq_pkg::NUM_PROCS; k++) begin
                    if (r_order[k] == r_id) begin
                        r_key[k] <= r_prio_in;
                    end
                end
                r_idx <= r_count;
            end
            apq_pkg::S_INS_SHIFT: begin
                if (shift_on) begin
                    r_order[ip] <= r_order[ip1];
                    r_key[ip]   <= r_key[ip1];
                    r_idx       <= r_idx - 1'b1;
                end else begin
                    r_order[ip] <= r_id;
                    r_key[ip]   <= r_prio_in;
                end
            end
            apq_pkg::S_DEQ_WR: begin
                r_res      <= deq_e;
                r_res_id   <= r_id;
                r_res_wait <= rd.timer;
            end
            apq_pkg::S_AGE_RD: r_id <= r_order[ip];
            apq_pkg::S_AGE_CHK: begin
                r_entry <= chk_e;
                r_rem   <= '0;
                r_bit   <= 4'd15;
                if (rd.timer == '1) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            apq_pkg::S_AGE_DIV: begin
                r_rem <= rem_nx;
                r_bit <= r_bit - 1'b1;
            end
            apq_pkg::S_AGE_WR: begin
                for (int k = 0; k < apq_pkg::NUM_PROCS; k++) begin
                    if (r_order[k] == r_id) begin
                        r_key[k] <= age_e.prio;
                    end
                end
                r_idx <= r_idx + 1'b1;
            end
            apq_pkg::S_SORT: begin
                for (int j = 0; j < apq_pkg::NUM_PROCS - 1; j++) begin
                    if ((j % 2) == int'(r_pass[0]) && (j + 1) < int'(r_count)
                            && r_key[j] > r_key[j+1]) begin
                        r_order[j]   <= r_order[j+1];
                        r_order[j+1] <= r_order[j];
                        r_key[j]     <= r_key[j+1];
                        r_key[j+1]   <= r_key[j];
                    end
                end
                r_pass <= r_pass + 1'b1;
            end
            default: ;
        endcase
        if (done_go) begin
            r_o_status <= r_res_status;
            r_o_id     <= r_res_id;
            r_o_wait   <= r_res_wait;
            r_o_min    <= r_res.wmin;
            r_o_max    <= r_res.wmax;
            r_o_sum    <= r_res.wsum;
            r_o_qcnt   <= r_res.qcnt;
            r_o_occ    <= r_count;
        end
    end

    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_out_id           = r_o_id;
    assign o_out_wait         = r_o_wait;
    assign o_out_wait_min     = r_o_min;
    assign o_out_wait_max     = r_o_max;
    assign o_out_wait_sum     = r_o_sum;
    assign o_out_times_queued = r_o_qcnt;
    assign o_occupancy        = r_o_occ;

endmodule

// ===== sv/apq_checker.sv =====
// Port-level checks for the aging priority queue, bound to the top level.
// Depends on aging_priority_queue_unit ports only.
module apq_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [3:0]  o_out_id,
    input logic [15:0] o_out_wait,
    input logic [15:0] o_out_wait_min,
    input logic [15:0] o_out_wait_max,
    input logic [4:0]  o_occupancy
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_occupancy <= 5'd16)
        else $error("occupancy out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != 2'd0 |-> o_out_id == 4'd0 && o_out_wait == 16'd0)
        else $error("failed request carries data");

    a_wait_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_wait <= o_out_wait_max && o_out_wait_min <= o_out_wait_max)
        else $error("wait statistics inconsistent");

endmodule

bind aging_priority_queue_unit apq_props u_apq_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_out_id       (o_out_id),
    .o_out_wait     (o_out_wait),
    .o_out_wait_min (o_out_wait_min),
    .o_out_wait_max (o_out_wait_max),
    .o_occupancy    (o_occupancy)
);
